@@ hdl/dfsc_pkg.sv @@
// shared types, constants and helpers of the dual fan speed controller
package dfsc_pkg;

  localparam int unsigned NumCfg = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [3:0] {
    CmdTick   = 4'd0,
    CmdTachA  = 4'd1,
    CmdTachB  = 4'd2,
    CmdButton = 4'd3,
    CmdAuto   = 4'd4,
    CmdManual = 4'd5,
    CmdSetRpm = 4'd6,
    CmdStop   = 4'd7,
    CmdStart  = 4'd8,
    CmdTemp   = 4'd9,
    CmdIdle   = 4'd10
  } cmd_e;

  localparam logic [CfgIdxW-1:0] RegMinRpm   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxRpm   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStepRpm  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDeadband = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDutyStep = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPeriod   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegTimeout  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegPpr      = 3'd7;

  typedef struct packed {
    logic [15:0] min_rpm;
    logic [15:0] max_rpm;
    logic [15:0] inc_rpm;
    logic [9:0]  deadband_rpm;
    logic [5:0]  duty_step;
    logic [15:0] period_ms;
    logic [19:0] temp_timeout_ms;
    logic [3:0]  pulses_per_rev;
  } cfg_t;

  // one classified item for the back end
  typedef struct packed {
    logic        is_tick;
    logic        tach_a;
    logic        tach_b;
    logic        button;
    logic        set_auto;
    logic        set_manual;
    logic        set_rpm;
    logic        stop;
    logic        start;
    logic        temp;
    logic [31:0] now_ms;
    logic [2:0]  levels;
    logic [15:0] rpm_req;
    logic [15:0] temp_tenths;
  } item_t;

  typedef struct packed {
    logic [6:0]  duty_pct;
    logic [9:0]  pwm_level;
    logic [15:0] speed_a;
    logic [15:0] speed_b;
    logic [15:0] target_rpm;
    logic        auto_on;
    logic        halted;
  } status_t;

  localparam logic [15:0] GoalReset = 16'd1500;
  localparam logic [6:0]  DutyReset = 7'd60;
  localparam logic [9:0]  PwmReset  = 10'd400;
  localparam logic [9:0]  PwmOff    = 10'd1000;
  localparam logic [6:0]  DutyMax   = 7'd100;
  localparam logic [16:0] RpmSat    = 17'd65535;
  localparam logic [15:0] RpmPerMin = 16'd60000;

  function automatic logic [15:0] table_rpm(input logic signed [15:0] t);
    logic [15:0] r;
    if (t < 16'sd400) r = 16'd700;
    else if (t < 16'sd500) r = 16'd1000;
    else if (t < 16'sd600) r = 16'd1500;
    else if (t < 16'sd700) r = 16'd2000;
    else if (t < 16'sd800) r = 16'd2500;
    else r = 16'd3000;
    return r;
  endfunction

  function automatic logic [9:0] level_of(input logic [6:0] d);
    logic [6:0] c;
    logic [9:0] inv;
    c = (d > DutyMax) ? DutyMax : d;
    inv = {3'd0, DutyMax - c};
    return (inv << 3) + (inv << 1);
  endfunction

endpackage

@@ hdl/dual_fan_speed_controller.sv @@
// dual fan speed controller top level: config registers, front end, back end
// a control tick holds the back end through both divisions and the adjust step
// control tick time is set by the shared 48-step divider run once per fan
// throughput: one ordinary event per cycle while the output is not stalled
// reset: async active low, registers to defaults, no clearing pass
module dual_fan_speed_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dfsc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dfsc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [3:0]                      command_i,
  input  logic [31:0]                     now_ms_i,
  input  logic                            mode_level_i,
  input  logic                            up_level_i,
  input  logic                            down_level_i,
  input  logic signed [15:0]              rpm_request_i,
  input  logic signed [15:0]              temp_tenths_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [6:0]                      duty_pct_o,
  output logic [9:0]                      pwm_level_o,
  output logic [15:0]                     speed_a_o,
  output logic [15:0]                     speed_b_o,
  output logic [15:0]                     target_rpm_o,
  output logic                            auto_on_o,
  output logic                            halted_o
);
  import dfsc_pkg::*;

  cfg_t    cfg_q;
  logic    q_valid, q_pop;
  item_t   q_item;
  status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_rpm <= 16'd500;
      cfg_q.max_rpm <= 16'd3300;
      cfg_q.inc_rpm <= 16'd500;
      cfg_q.deadband_rpm <= 10'd80;
      cfg_q.duty_step <= 6'd2;
      cfg_q.period_ms <= 16'd1000;
      cfg_q.temp_timeout_ms <= 20'd10000;
      cfg_q.pulses_per_rev <= 4'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMinRpm:   cfg_q.min_rpm <= cfg_data_i[15:0];
        RegMaxRpm:   cfg_q.max_rpm <= cfg_data_i[15:0];
        RegStepRpm:  cfg_q.inc_rpm <= cfg_data_i[15:0];
        RegDeadband: cfg_q.deadband_rpm <= cfg_data_i[9:0];
        RegDutyStep: cfg_q.duty_step <= cfg_data_i[5:0];
        RegPeriod:   cfg_q.period_ms <= cfg_data_i[15:0];
        RegTimeout:  cfg_q.temp_timeout_ms <= cfg_data_i[19:0];
        RegPpr:      cfg_q.pulses_per_rev <= cfg_data_i[3:0];
        default:     cfg_q <= cfg_q;
      endcase
    end
  end

  dfsc_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .command_i,
    .now_ms_i,
    .mode_level_i,
    .up_level_i,
    .down_level_i,
    .rpm_request_i,
    .temp_tenths_i,
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  dfsc_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o,
    .out_stall_i,
    .status_o    (status)
  );

  assign duty_pct_o = status.duty_pct;
  assign pwm_level_o = status.pwm_level;
  assign speed_a_o = status.speed_a;
  assign speed_b_o = status.speed_b;
  assign target_rpm_o = status.target_rpm;
  assign auto_on_o = status.auto_on;
  assign halted_o = status.halted;

endmodule

@@ hdl/dfsc_front.sv @@
// front end: takes input beats, decodes the command and queues the item
module dfsc_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [3:0]             command_i,
  input  logic [31:0]            now_ms_i,
  input  logic                   mode_level_i,
  input  logic                   up_level_i,
  input  logic                   down_level_i,
  input  logic signed [15:0]     rpm_request_i,
  input  logic signed [15:0]     temp_tenths_i,
  output logic                   q_valid_o,
  output dfsc_pkg::item_t        q_item_o,
  input  logic                   q_pop_i
);
  import dfsc_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  item_t              mem_q [QueueDepth];
  logic [PtrW-1:0]    wr_q, rd_q;
  logic [PtrW:0]      cnt_q;
  item_t              item;
  logic               push;

  always_comb begin
    item = '0;
    item.now_ms = now_ms_i;
    item.levels = {down_level_i, up_level_i, mode_level_i};
    item.rpm_req = rpm_request_i;
    item.temp_tenths = temp_tenths_i;
    case (command_i)
      CmdTick:   item.is_tick = 1'b1;
      CmdTachA:  item.tach_a = 1'b1;
      CmdTachB:  item.tach_b = 1'b1;
      CmdButton: item.button = 1'b1;
      CmdAuto:   item.set_auto = 1'b1;
      CmdManual: item.set_manual = 1'b1;
      CmdSetRpm: item.set_rpm = 1'b1;
      CmdStop:   item.stop = 1'b1;
      CmdStart:  item.start = 1'b1;
      CmdTemp:   item.temp = 1'b1;
      default:   item.is_tick = 1'b0;
    endcase
  end

  assign in_stall_o = (cnt_q == (PtrW+1)'(QueueDepth));
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (q_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
    end
  end

endmodule

@@ hdl/dfsc_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
module dfsc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] num_i,
  input  logic [35:0] den_i,
  output logic        done_o,
  output logic [15:0] quo_o
);
  import dfsc_pkg::*;

  logic [47:0] num_q;
  logic [36:0] rem_q;
  logic [35:0] den_q;
  logic [47:0] quo_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [36:0] shifted;
  logic [37:0] diff;

  assign shifted = {rem_q[35:0], num_q[47]};
  assign diff = {1'b0, shifted} - {2'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 6'd47;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[46:0], 1'b0};
      if (!diff[37]) begin
        rem_q <= diff[36:0];
        quo_q <= {quo_q[46:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[46:0], 1'b0};
      end
    end
  end

  assign quo_o = (quo_q > {31'd0, RpmSat}) ? RpmSat[15:0] : quo_q[15:0];

endmodule

@@ hdl/dfsc_back.sv @@
// back end: applies queued items to the controller state, control ticks that are due divide
module dfsc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dfsc_pkg::cfg_t   cfg_i,
  input  logic             q_valid_i,
  input  dfsc_pkg::item_t  q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dfsc_pkg::status_t status_o
);
  import dfsc_pkg::*;

  typedef enum logic [2:0] {StIdle, StDivA, StWaitA, StDivB, StWaitB, StAdjust} state_e;

  state_e      state_q;
  logic [31:0] pca_q, pcb_q, last_q, tstamp_q, now_q;
  logic signed [15:0] temp_q;
  logic        seen_q, auto_q, stop_q;
  logic [15:0] goal_q, manual_q, rpma_q, rpmb_q;
  logic [6:0]  duty_q;
  logic [9:0]  pwm_q;
  logic [2:0]  prev_q;
  logic [47:0] prod_q;
  logic [35:0] den_q;
  logic        div_start;
  logic        div_done;
  logic [15:0] div_quo;
  logic [15:0] per;
  logic [3:0]  ppr;
  logic [31:0] elapsed;
  logic        can_take;
  logic        out_set;
  item_t       it;
  logic [16:0] up_sum;
  logic [15:0] mg_btn, goal_btn;
  logic        auto_btn;
  logic signed [16:0] req;
  logic [15:0] req_cl;
  logic [15:0] goal_eff;
  logic [16:0] avg_sum;
  logic [15:0] avg;
  logic [16:0] lo_b, hi_b;
  logic [6:0]  duty_up, duty_new;
  logic [7:0]  duty_add;
  logic [31:0] tage;

  dfsc_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign it = q_item_i;
  assign per = (cfg_i.period_ms == '0) ? 16'd1 : cfg_i.period_ms;
  assign ppr = (cfg_i.pulses_per_rev == '0) ? 4'd1 : cfg_i.pulses_per_rev;
  assign elapsed = it.now_ms - last_q;
  assign can_take = (state_q == StIdle) && q_valid_i && !(out_valid_o && out_stall_i);
  assign q_pop_o = can_take;
  assign div_start = (state_q == StDivA) || (state_q == StDivB);
  assign out_set = (can_take && !(it.is_tick && elapsed >= {16'd0, per})) ||
                   (state_q == StAdjust);

  always_comb begin
    auto_btn = auto_q;
    mg_btn = manual_q;
    goal_btn = goal_q;
    if (it.levels[0] && !prev_q[0]) begin
      auto_btn = !auto_q;
      if (auto_q) goal_btn = manual_q;
    end
    up_sum = {1'b0, manual_q} + {1'b0, cfg_i.inc_rpm};
    if (!auto_btn) begin
      if (it.levels[1] && !prev_q[1]) begin
        if (manual_q < cfg_i.max_rpm) mg_btn = up_sum[16] ? 16'hFFFF : up_sum[15:0];
        goal_btn = mg_btn;
      end
      if (it.levels[2] && !prev_q[2]) begin
        if (mg_btn > cfg_i.min_rpm)
          mg_btn = (mg_btn > cfg_i.inc_rpm) ? mg_btn - cfg_i.inc_rpm : 16'd0;
        goal_btn = mg_btn;
      end
    end
  end

  always_comb begin
    req = $signed({it.rpm_req[15], it.rpm_req});
    if (req < $signed({1'b0, cfg_i.min_rpm})) req = $signed({1'b0, cfg_i.min_rpm});
    if (req > $signed({1'b0, cfg_i.max_rpm})) req = $signed({1'b0, cfg_i.max_rpm});
    req_cl = req[15:0];
  end

  always_comb begin
    tage = now_q - tstamp_q;
    goal_eff = goal_q;
    if (auto_q)
      goal_eff = (seen_q && tage < {12'd0, cfg_i.temp_timeout_ms}) ? table_rpm(temp_q) : '0;
    avg_sum = {1'b0, rpma_q} + {1'b0, rpmb_q};
    avg = avg_sum[16:1];
    lo_b = {1'b0, goal_eff} - {7'd0, cfg_i.deadband_rpm};
    hi_b = {1'b0, goal_eff} + {7'd0, cfg_i.deadband_rpm};
    duty_add = {1'b0, duty_q} + {2'b0, cfg_i.duty_step};
    duty_up = (duty_add > {1'b0, DutyMax}) ? DutyMax : duty_add[6:0];
    duty_new = duty_q;
    if ({1'b0, goal_eff} > {7'd0, cfg_i.deadband_rpm} && {1'b0, avg} < lo_b) begin
      if (duty_q < DutyMax) duty_new = duty_up;
    end else if ({1'b0, avg} > hi_b) begin
      if (duty_q > {1'b0, cfg_i.duty_step}) duty_new = duty_q - {1'b0, cfg_i.duty_step};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pca_q <= '0; pcb_q <= '0; last_q <= '0; tstamp_q <= '0;
      temp_q <= '0; seen_q <= 1'b0; auto_q <= 1'b0; stop_q <= 1'b0;
      goal_q <= GoalReset; manual_q <= GoalReset; duty_q <= DutyReset;
      rpma_q <= '0; rpmb_q <= '0; prev_q <= '0; pwm_q <= PwmReset;
      out_valid_o <= 1'b0;
      now_q <= '0; prod_q <= '0; den_q <= '0;
    end else begin
      if (out_set) out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (can_take) begin
            if (it.is_tick) begin
              if (elapsed >= {16'd0, per}) begin
                last_q <= it.now_ms;
                now_q <= it.now_ms;
                prod_q <= 48'(pca_q) * 48'(RpmPerMin);
                den_q <= 36'(ppr) * 36'(elapsed);
                state_q <= StDivA;
              end
            end else begin
              if (it.tach_a) pca_q <= pca_q + 1'b1;
              if (it.tach_b) pcb_q <= pcb_q + 1'b1;
              if (it.button) begin
                auto_q <= auto_btn;
                manual_q <= mg_btn;
                goal_q <= goal_btn;
                prev_q <= it.levels;
              end
              if (it.set_auto) auto_q <= 1'b1;
              if (it.set_manual) begin
                auto_q <= 1'b0;
                goal_q <= manual_q;
              end
              if (it.set_rpm) begin
                manual_q <= req_cl;
                goal_q <= req_cl;
                auto_q <= 1'b0;
              end
              if (it.stop) begin
                stop_q <= 1'b1;
                pwm_q <= PwmOff;
              end
              if (it.start) stop_q <= 1'b0;
              if (it.temp) begin
                temp_q <= it.temp_tenths;
                seen_q <= 1'b1;
                tstamp_q <= it.now_ms;
              end
            end
          end
        end
        StDivA: begin
          prod_q <= 48'(pcb_q) * 48'(RpmPerMin);
          state_q <= StWaitA;
        end
        StWaitA: begin
          if (div_done) begin
            rpma_q <= div_quo;
            state_q <= StDivB;
          end
        end
        StDivB: state_q <= StWaitB;
        StWaitB: begin
          if (div_done) begin
            rpmb_q <= div_quo;
            pca_q <= '0;
            pcb_q <= '0;
            state_q <= StAdjust;
          end
        end
        StAdjust: begin
          goal_q <= goal_eff;
          if (stop_q || goal_eff == '0) begin
            duty_q <= '0;
            pwm_q <= PwmOff;
          end else begin
            duty_q <= duty_new;
            pwm_q <= level_of(duty_new);
          end
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign status_o.duty_pct = duty_q;
  assign status_o.pwm_level = pwm_q;
  assign status_o.speed_a = rpma_q;
  assign status_o.speed_b = rpmb_q;
  assign status_o.target_rpm = goal_q;
  assign status_o.auto_on = auto_q;
  assign status_o.halted = stop_q;

endmodule

@@ hdl/dfsc_checker.sv @@
// port-level checker for the dual fan speed controller and its bind
module dfsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] duty_pct_o,
  input logic [9:0] pwm_level_o,
  input logic       halted_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pwm_level_o))
    else $error("result dropped or changed while stalled");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_pct_o <= 7'd100)
    else $error("duty above 100");

  a_halt_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halted_o |-> pwm_level_o == 10'd1000)
    else $error("stopped fan with nonzero drive");

endmodule

bind dual_fan_speed_controller dfsc_checker u_dfsc_checker (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_stall_i,
  .duty_pct_o,
  .pwm_level_o,
  .halted_o
);

@@ tb/sv/tb.sv @@
// self-checking testbench of the dual fan speed controller
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dfsc_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned NumRandom = 1300;

  typedef struct packed {
    logic [6:0]  duty;
    logic [9:0]  pwm;
    logic [15:0] spd_a;
    logic [15:0] spd_b;
    logic [15:0] goal;
    logic        auto_on;
    logic        halted;
  } status_exp_t;

  typedef struct {
    cmd_e        cmd;
    logic [31:0] now;
    logic [2:0]  lvl;
    logic [15:0] req;
    logic [15:0] temp;
    bit          has_exp;
    status_exp_t exp_st;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [3:0] command_i = CmdIdle;
  logic [31:0] now_ms_i = '0;
  logic mode_level_i = 1'b0;
  logic up_level_i = 1'b0;
  logic down_level_i = 1'b0;
  logic signed [15:0] rpm_request_i = '0;
  logic signed [15:0] temp_tenths_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [6:0] duty_pct_o;
  logic [9:0] pwm_level_o;
  logic [15:0] speed_a_o, speed_b_o, target_rpm_o;
  logic auto_on_o, halted_o;

  dual_fan_speed_controller i_dut (.*);

  // model state
  cfg_t        fan_cfg;
  logic [31:0] cnt_a, cnt_b, last_upd, temp_stamp;
  logic signed [15:0] temp_val;
  bit          temp_seen, auto_sel, stopped;
  logic [15:0] goal, man_goal, rpm_a, rpm_b;
  logic [6:0]  duty;
  logic [9:0]  pwm;
  logic [2:0]  prev_btn;

  status_exp_t status_q[$];
  int unsigned n_err = 0;
  int unsigned cycles = 0;
  bit idle_free = 1'b0;
  bit hold_rx = 1'b0;
  logic [31:0] clock_ms = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic model_reset();
    fan_cfg = '{min_rpm: 500, max_rpm: 3300, inc_rpm: 500, deadband_rpm: 80,
                duty_step: 2, period_ms: 1000, temp_timeout_ms: 10000, pulses_per_rev: 2};
    cnt_a = 0; cnt_b = 0; last_upd = 0; temp_stamp = 0; temp_val = 0;
    temp_seen = 0; auto_sel = 0; stopped = 0; goal = 1500; man_goal = 1500;
    duty = 60; rpm_a = 0; rpm_b = 0; prev_btn = 0; pwm = 400;
  endtask

  function automatic logic [15:0] rpm_of(logic [31:0] pulses, logic [31:0] el);
    logic [63:0] ppr, r;
    ppr = (fan_cfg.pulses_per_rev == 0) ? 64'd1 : 64'(fan_cfg.pulses_per_rev);
    r = (64'(pulses) * 64'd60000) / (ppr * 64'(el));
    return (r > 64'd65535) ? 16'hffff : r[15:0];
  endfunction

  function automatic logic [15:0] temp_goal(logic signed [15:0] t);
    if (t < 400) return 700;
    if (t < 500) return 1000;
    if (t < 600) return 1500;
    if (t < 700) return 2000;
    if (t < 800) return 2500;
    return 3000;
  endfunction

  task automatic control_update(logic [31:0] now);
    logic [31:0] per, el;
    int signed avg, g, db, dn;
    per = (fan_cfg.period_ms == 0) ? 32'd1 : 32'(fan_cfg.period_ms);
    el = now - last_upd;
    if (el < per) return;
    last_upd = now;
    rpm_a = rpm_of(cnt_a, el);
    rpm_b = rpm_of(cnt_b, el);
    cnt_a = 0; cnt_b = 0;
    if (auto_sel) begin
      if (temp_seen && (now - temp_stamp) < 32'(fan_cfg.temp_timeout_ms)) goal = temp_goal(temp_val);
      else goal = 0;
    end
    if (stopped || goal == 0) begin
      duty = 0; pwm = 1000;
      return;
    end
    avg = (int'(rpm_a) + int'(rpm_b)) / 2;
    g = int'(goal);
    db = int'(fan_cfg.deadband_rpm);
    dn = int'(duty);
    if (avg < g - db) begin
      if (dn < 100) begin
        dn += int'(fan_cfg.duty_step);
        if (dn > 100) dn = 100;
      end
    end else if (avg > g + db) begin
      if (dn > int'(fan_cfg.duty_step)) dn -= int'(fan_cfg.duty_step);
    end
    duty = dn[6:0];
    pwm = 10'((100 - dn) * 10);
  endtask

  task automatic press_buttons(logic [2:0] lvl);
    int unsigned mg;
    if (lvl[0] && !prev_btn[0]) begin
      auto_sel = !auto_sel;
      if (!auto_sel) goal = man_goal;
    end
    if (!auto_sel) begin
      if (lvl[1] && !prev_btn[1]) begin
        if (man_goal < fan_cfg.max_rpm) begin
          mg = man_goal + fan_cfg.inc_rpm;
          man_goal = (mg > 65535) ? 16'hffff : mg[15:0];
        end
        goal = man_goal;
      end
      if (lvl[2] && !prev_btn[2]) begin
        if (man_goal > fan_cfg.min_rpm)
          man_goal = (man_goal > fan_cfg.inc_rpm) ? man_goal - fan_cfg.inc_rpm : 16'd0;
        goal = man_goal;
      end
    end
    prev_btn = lvl;
  endtask

  function automatic status_exp_t fan_status();
    return '{duty: duty, pwm: pwm, spd_a: rpm_a, spd_b: rpm_b, goal: goal,
             auto_on: auto_sel, halted: stopped};
  endfunction

  task automatic predict_status(stim_row_t r);
    int signed q;
    case (r.cmd)
      CmdTick: control_update(r.now);
      CmdTachA: cnt_a = cnt_a + 1;
      CmdTachB: cnt_b = cnt_b + 1;
      CmdButton: press_buttons(r.lvl);
      CmdAuto: auto_sel = 1;
      CmdManual: begin
        auto_sel = 0;
        goal = man_goal;
      end
      CmdSetRpm: begin
        q = int'($signed(r.req));
        if (q < int'(fan_cfg.min_rpm)) q = int'(fan_cfg.min_rpm);
        if (q > int'(fan_cfg.max_rpm)) q = int'(fan_cfg.max_rpm);
        man_goal = q[15:0]; goal = q[15:0]; auto_sel = 0;
      end
      CmdStop: begin
        stopped = 1;
        pwm = 1000;
      end
      CmdStart: stopped = 0;
      CmdTemp: begin
        temp_val = r.temp; temp_seen = 1; temp_stamp = r.now;
      end
      default: ;
    endcase
  endtask

  task automatic wait_cycles(int unsigned n);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic send_beat(stim_row_t r);
    status_exp_t s;
    predict_status(r);
    s = fan_status();
    if (r.has_exp && s != r.exp_st) begin
      n_err++;
      if (n_err <= 10) $display("table row mismatch with model: exp %h got %h", r.exp_st, s);
    end
    status_q.push_back(s);
    command_i <= r.cmd;
    now_ms_i <= r.now;
    {down_level_i, up_level_i, mode_level_i} <= r.lvl;
    rpm_request_i <= r.req;
    temp_tenths_i <= r.temp;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    if (!idle_free && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      wait_cycles($urandom_range(1, 6));
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(negedge clk_i);
    wait_cycles(250);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgDataW'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegMinRpm: fan_cfg.min_rpm = val[15:0];
      RegMaxRpm: fan_cfg.max_rpm = val[15:0];
      RegStepRpm: fan_cfg.inc_rpm = val[15:0];
      RegDeadband: fan_cfg.deadband_rpm = val[9:0];
      RegDutyStep: fan_cfg.duty_step = val[5:0];
      RegPeriod: fan_cfg.period_ms = val[15:0];
      RegTimeout: fan_cfg.temp_timeout_ms = val[19:0];
      default: fan_cfg.pulses_per_rev = val[3:0];
    endcase
  endtask

  function automatic stim_row_t mk(cmd_e c, logic [31:0] now, logic [2:0] lvl = 0,
                                    logic [15:0] req = 0, logic [15:0] temp = 0);
    stim_row_t r;
    r.cmd = c; r.now = now; r.lvl = lvl; r.req = req; r.temp = temp;
    r.has_exp = 0; r.exp_st = '0;
    return r;
  endfunction

  function automatic stim_row_t mkx(stim_row_t r, status_exp_t e);
    r.has_exp = 1; r.exp_st = e;
    return r;
  endfunction

  function automatic stim_row_t rand_row();
    int unsigned k;
    cmd_e c;
    k = $urandom_range(99);
    if (k < 40) c = ($urandom_range(1)) ? CmdTachA : CmdTachB;
    else if (k < 55) c = CmdTick;
    else if (k < 70) c = CmdButton;
    else if (k < 80) c = CmdTemp;
    else if (k < 97) c = cmd_e'($urandom_range(4, 10));
    else c = cmd_e'($urandom_range(11, 15));
    if (c == CmdTick) clock_ms += ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1500);
    else clock_ms += $urandom_range(0, 40);
    return mk(c, clock_ms, 3'($urandom_range(7)), 16'($urandom), ($urandom_range(1)) ?
              16'($urandom_range(200, 900)) : 16'($urandom));
  endfunction

  // result checker
  always @(posedge clk_i) begin
    status_exp_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{duty: duty_pct_o, pwm: pwm_level_o, spd_a: speed_a_o, spd_b: speed_b_o,
              goal: target_rpm_o, auto_on: auto_on_o, halted: halted_o};
      if (status_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected status beat %h", got);
      end else begin
        want = status_q.pop_front();
        if (got != want) begin
          n_err++;
          if (n_err <= 10)
            $display("status mismatch: exp duty %0d pwm %0d a %0d b %0d goal %0d auto %0b halt %0b, got duty %0d pwm %0d a %0d b %0d goal %0d auto %0b halt %0b",
                     want.duty, want.pwm, want.spd_a, want.spd_b, want.goal, want.auto_on,
                     want.halted, got.duty, got.pwm, got.spd_a, got.spd_b, got.goal,
                     got.auto_on, got.halted);
        end
      end
    end
  end

  // receiver stall
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_rx) out_stall_i <= 1'b1;
      else out_stall_i <= (!idle_free && $urandom_range(99) < 9);
    end
  end

  initial begin
    stim_row_t tbl[$];
    int unsigned t;
    model_reset();
    wait_cycles(8);
    rst_ni <= 1'b1;
    wait_cycles(2);

    tbl.push_back(mkx(mk(CmdIdle, 0), '{60, 400, 0, 0, 1500, 0, 0}));
    tbl.push_back(mk(CmdTachA, 10));
    tbl.push_back(mk(CmdTachA, 20));
    tbl.push_back(mk(CmdTachB, 30));
    tbl.push_back(mk(CmdTick, 500));
    tbl.push_back(mk(CmdTick, 1000));
    tbl.push_back(mkx(mk(CmdSetRpm, 1100, 0, 16'h8000), '{62, 380, 60, 30, 500, 0, 0}));
    tbl.push_back(mkx(mk(CmdSetRpm, 1200, 0, 16'h7fff), '{62, 380, 60, 30, 3300, 0, 0}));
    tbl.push_back(mk(CmdButton, 1300, 3'b010));
    tbl.push_back(mk(CmdButton, 1310, 3'b100));
    tbl.push_back(mk(CmdButton, 1320, 3'b000));
    tbl.push_back(mk(CmdButton, 1330, 3'b111));
    tbl.push_back(mk(CmdButton, 1340, 3'b000));
    tbl.push_back(mk(CmdTemp, 1400, 0, 0, 16'h8000));
    tbl.push_back(mk(CmdAuto, 1500));
    tbl.push_back(mk(CmdTick, 2600));
    tbl.push_back(mk(CmdTemp, 2700, 0, 0, 16'h7fff));
    tbl.push_back(mk(CmdTick, 32'hffff_ff00));
    tbl.push_back(mk(CmdManual, 32'hffff_ff10));
    tbl.push_back(mk(CmdStop, 32'hffff_ff20));
    tbl.push_back(mk(CmdTick, 32'h0000_0400));
    tbl.push_back(mk(CmdStart, 32'h0000_0410));
    tbl.push_back(mk(cmd_e'(4'd15), 32'h0000_0420));
    tbl.push_back(mk(CmdTick, 32'h0000_0900));
    foreach (tbl[i]) send_beat(tbl[i]);
    clock_ms = 32'h0000_0900;

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(RegMinRpm, 0); write_reg(RegMaxRpm, 16'hffff);
          write_reg(RegStepRpm, 16'hffff); write_reg(RegDeadband, 0);
          write_reg(RegDutyStep, 50); write_reg(RegPeriod, 1);
          write_reg(RegTimeout, 20'hfffff); write_reg(RegPpr, 1);
        end
        1: begin
          write_reg(RegMinRpm, 16'hffff); write_reg(RegMaxRpm, 0);
          write_reg(RegDeadband, 1023); write_reg(RegDutyStep, 1);
          write_reg(RegPeriod, 16'hffff); write_reg(RegTimeout, 1);
          write_reg(RegPpr, 8); write_reg(RegStepRpm, 0);
        end
        2: begin
          write_reg(RegMinRpm, $urandom_range(0, 1000));
          write_reg(RegMaxRpm, $urandom_range(2000, 5000));
          write_reg(RegStepRpm, $urandom_range(100, 800));
          write_reg(RegDeadband, $urandom_range(0, 200));
          write_reg(RegDutyStep, $urandom_range(1, 10));
          write_reg(RegPeriod, 0); write_reg(RegPpr, 0);
          write_reg(RegTimeout, $urandom_range(500, 5000));
        end
        default: begin
          write_reg(RegMinRpm, 500); write_reg(RegMaxRpm, 3300);
          write_reg(RegStepRpm, 500); write_reg(RegDeadband, 80);
          write_reg(RegDutyStep, 2); write_reg(RegPeriod, 1000);
          write_reg(RegTimeout, 10000); write_reg(RegPpr, 2);
        end
      endcase
      idle_free = (ph == 1);
      if (ph == 2) fork
        begin
          hold_rx = 1'b1;
          t = 0;
          while (t < 300) begin
            @(negedge clk_i);
            t++;
          end
          hold_rx = 1'b0;
        end
      join_none
      repeat (NumRandom / 4) send_beat(rand_row());
      idle_free = 1'b0;
    end

    drain();
    if (n_err == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
